// ===== rtl/nrc_pkg.sv =====
`default_nettype none
package nrc_pkg;

   localparam int ENDPOINT_FIELD_BITS = 32;
   localparam int INDEX_OUT_BITS      = 6;
   localparam int COUNT_OUT_BITS      = 6;
   localparam int REQ_DATA_BITS       = 64;
   localparam int RSP_DATA_BITS       = 24;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SWEEP,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic start_set;
      logic step;
      logic next_item;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic j_last;
      logic i_last;
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/nested_range_count_core.sv =====
// Flow: after the last load of a set, each stored range gets one read sweep of the endpoint
// memory (one stored range compared per cycle), a drain state and then its result transfer.
// Throughput: one range loaded per cycle while in the load state; none is taken in the result
// phase, which does one read sweep of the endpoint memory per result.
// Reset: synchronous, active high; clears the fill count, overflow and controller.
`default_nettype none
module nested_range_count_core #(
   parameter int MAX_RANGES    = 64,
   parameter int ENDPOINT_BITS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [31:0] range_start, [63:32] range_end
   input  wire logic [nrc_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // last_range
   input  wire logic                               req_tlast,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [5:0] range_index, [11:6] inner_count, [17:12] outer_count,
   // [18] overflow_flag, [23:19] zero
   output logic [nrc_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   // last_result
   output logic                                    rsp_tlast
);

   localparam int FieldW = nrc_pkg::ENDPOINT_FIELD_BITS;
   localparam int SB     = (ENDPOINT_BITS < FieldW) ? ENDPOINT_BITS : FieldW;
   localparam int IdxW   = nrc_pkg::INDEX_OUT_BITS;
   localparam int CntW   = nrc_pkg::COUNT_OUT_BITS;
   localparam int PadW   = nrc_pkg::RSP_DATA_BITS - IdxW - 2 * CntW - 1;

   nrc_pkg::cmd_type    cmd;
   nrc_pkg::status_type status;

   logic [IdxW-1:0] range_index;
   logic [CntW-1:0] inner_count;
   logic [CntW-1:0] outer_count;
   logic            overflow_flag;

   nrc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tlast  (rsp_tlast)
   );

   nrc_datapath #(
      .MAX_RANGES (MAX_RANGES),
      .STORE_BITS (SB)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .load_start    (req_tdata[SB-1:0]),
      .load_end      (req_tdata[FieldW+SB-1:FieldW]),
      .range_index   (range_index),
      .inner_count   (inner_count),
      .outer_count   (outer_count),
      .overflow_flag (overflow_flag)
   );

   assign rsp_tdata = {{PadW{1'b0}}, overflow_flag, outer_count, inner_count, range_index};

endmodule
`default_nettype wire

// ===== rtl/nrc_ctrl.sv =====
`default_nettype none
module nrc_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   input  wire logic               req_tlast,
   input  wire logic               rsp_tready,
   input  wire nrc_pkg::status_type status,
   output nrc_pkg::cmd_type        cmd,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   output logic                    rsp_tlast
);

   nrc_pkg::state_type state_ff;
   nrc_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nrc_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      rsp_tlast  = status.i_last;
      case (state_ff)
         nrc_pkg::ST_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_tlast) begin
                  cmd.start_set = 1'b1;
                  state_in      = nrc_pkg::ST_SWEEP;
               end
            end
         end
         nrc_pkg::ST_SWEEP: begin
            cmd.step = 1'b1;
            if (status.j_last) begin
               state_in = nrc_pkg::ST_DRAIN;
            end
         end
         nrc_pkg::ST_DRAIN: begin
            state_in = nrc_pkg::ST_EMIT;
         end
         nrc_pkg::ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (status.i_last) begin
                  cmd.finish = 1'b1;
                  state_in   = nrc_pkg::ST_LOAD;
               end else begin
                  cmd.next_item = 1'b1;
                  state_in      = nrc_pkg::ST_SWEEP;
               end
            end
         end
         default: begin
            state_in = nrc_pkg::ST_LOAD;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/nrc_datapath.sv =====
`default_nettype none
module nrc_datapath #(
   parameter int MAX_RANGES = 64,
   parameter int STORE_BITS = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire nrc_pkg::cmd_type                    cmd,
   output nrc_pkg::status_type                      status,
   input  wire logic [STORE_BITS-1:0]               load_start,
   input  wire logic [STORE_BITS-1:0]               load_end,
   output logic [nrc_pkg::INDEX_OUT_BITS-1:0]       range_index,
   output logic [nrc_pkg::COUNT_OUT_BITS-1:0]       inner_count,
   output logic [nrc_pkg::COUNT_OUT_BITS-1:0]       outer_count,
   output logic                                     overflow_flag
);

   localparam int IW   = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CW   = $clog2(MAX_RANGES + 1);
   localparam int IdxW = nrc_pkg::INDEX_OUT_BITS;
   localparam int CntW = nrc_pkg::COUNT_OUT_BITS;

   logic [STORE_BITS-1:0] start_mem [MAX_RANGES];
   logic [STORE_BITS-1:0] end_mem   [MAX_RANGES];

   logic [CW-1:0]         count_ff;
   logic                  overflow_ff;
   logic [IW-1:0]         i_ff;
   logic [IW-1:0]         j_ff;
   logic [IW-1:0]         cmp_j_ff;
   logic                  cmp_valid_ff;
   logic [STORE_BITS-1:0] si_ff, ei_ff, sj_ff, ej_ff;
   logic [IW-1:0]         inner_ff, outer_ff;
   logic [CW-1:0]         count_m1;
   logic                  full;
   logic                  dup, self, inner_hit, outer_hit;

   assign full     = (count_ff == CW'(MAX_RANGES));
   assign count_m1 = count_ff - CW'(1);

   assign status.j_last = (j_ff == count_m1[IW-1:0]);
   assign status.i_last = (i_ff == count_m1[IW-1:0]);

   always_ff @(posedge clock) begin
      if (cmd.load && !full) begin
         start_mem[count_ff[IW-1:0]] <= load_start;
         end_mem[count_ff[IW-1:0]]   <= load_end;
      end
   end

   always_ff @(posedge clock) begin
      si_ff    <= start_mem[i_ff];
      ei_ff    <= end_mem[i_ff];
      sj_ff    <= start_mem[j_ff];
      ej_ff    <= end_mem[j_ff];
      cmp_j_ff <= j_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         cmp_valid_ff <= cmd.step;
         if (cmd.finish) begin
            count_ff    <= '0;
            overflow_ff <= 1'b0;
            i_ff        <= '0;
         end else if (cmd.load) begin
            if (full) begin
               overflow_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + CW'(1);
            end
         end
         if (cmd.start_set) begin
            i_ff <= '0;
            j_ff <= '0;
         end else if (cmd.next_item) begin
            i_ff <= i_ff + IW'(1);
            j_ff <= '0;
         end else if (cmd.step) begin
            j_ff <= j_ff + IW'(1);
         end
      end
   end

   // exact duplicate counts only when loaded before the range under test
   assign self      = (cmp_j_ff == i_ff);
   assign dup       = (sj_ff == si_ff) && (ej_ff == ei_ff) && (cmp_j_ff > i_ff);
   assign inner_hit = (sj_ff >= si_ff) && (ej_ff <= ei_ff) && !self && !dup;
   assign outer_hit = (sj_ff <= si_ff) && (ej_ff >= ei_ff) && !self && !dup;

   always_ff @(posedge clock) begin
      if (cmd.start_set || cmd.next_item) begin
         inner_ff <= '0;
         outer_ff <= '0;
      end else if (cmp_valid_ff) begin
         inner_ff <= inner_ff + IW'(inner_hit);
         outer_ff <= outer_ff + IW'(outer_hit);
      end
   end

   assign range_index   = IdxW'(i_ff);
   assign inner_count   = CntW'(inner_ff);
   assign outer_count   = CntW'(outer_ff);
   assign overflow_flag = overflow_ff;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;

   localparam int HELD_MAX = 64;

   typedef struct {
      bit [31:0] lo;
      bit [31:0] hi;
      bit        last;
   } span_type;

   typedef struct {
      bit [5:0] index;
      bit [5:0] inner;
      bit [5:0] outer;
      bit       ovf;
      bit       last;
   } tally_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [nrc_pkg::REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                              req_tlast = 1'b0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [nrc_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic                              rsp_tlast;

   nested_range_count_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   span_type  pending_spans[$];
   tally_type tally_q[$];

   bit [31:0] held_start[HELD_MAX];
   bit [31:0] held_end[HELD_MAX];
   int        held_count = 0;
   bit        held_overflow = 1'b0;

   int        error_count = 0;
   int        results_seen = 0;
   bit        req_taken = 1'b0;
   bit        rsp_taken = 1'b0;
   int        send_wait = 0;
   bit        send_calm = 1'b0;
   int        recv_wait = 0;
   bit        recv_calm = 1'b0;
   int        long_hold = 0;
   bit        hold_done = 1'b0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic bit counts_toward(input int i, input int j, input bit inner);
      bit hit;
      if (i == j) return 1'b0;
      if (inner)
         hit = (held_start[j] >= held_start[i]) && (held_end[j] <= held_end[i]);
      else
         hit = (held_start[j] <= held_start[i]) && (held_end[j] >= held_end[i]);
      // exact duplicate counts only when loaded earlier
      if (hit && held_start[j] == held_start[i] && held_end[j] == held_end[i] && j > i)
         hit = 1'b0;
      return hit;
   endfunction

   task automatic absorb_range(input bit [31:0] lo, input bit [31:0] hi, input bit last);
      tally_type t;
      int        n_in;
      int        n_out;
      if (held_count < HELD_MAX) begin
         held_start[held_count] = lo;
         held_end[held_count]   = hi;
         held_count++;
      end else begin
         held_overflow = 1'b1;
      end
      if (last) begin
         for (int i = 0; i < held_count; i++) begin
            n_in  = 0;
            n_out = 0;
            for (int j = 0; j < held_count; j++) begin
               if (counts_toward(i, j, 1'b1)) n_in++;
               if (counts_toward(i, j, 1'b0)) n_out++;
            end
            t.index = i[5:0];
            t.inner = n_in[5:0];
            t.outer = n_out[5:0];
            t.ovf   = held_overflow;
            t.last  = (i + 1 == held_count);
            tally_q.push_back(t);
         end
         held_count    = 0;
         held_overflow = 1'b0;
      end
   endtask

   // sample both channels, predict and check
   always @(posedge clock) begin
      tally_type t;
      if (reset) begin
         req_taken = 1'b0;
         rsp_taken = 1'b0;
      end else begin
         req_taken = req_tvalid && req_tready;
         rsp_taken = rsp_tvalid && rsp_tready;
         if (req_taken) absorb_range(req_tdata[31:0], req_tdata[63:32], req_tlast);
         if (rsp_taken) begin
            results_seen++;
            if (rsp_tlast) recv_calm = ($urandom_range(0, 3) == 0);
            if (tally_q.size() == 0) begin
               report_mismatch("unexpected result tdata", rsp_tdata, 0);
            end else begin
               t = tally_q.pop_front();
               if (rsp_tdata[5:0] != t.index)
                  report_mismatch("range_index", rsp_tdata[5:0], t.index);
               if (rsp_tdata[11:6] != t.inner)
                  report_mismatch("inner_count", rsp_tdata[11:6], t.inner);
               if (rsp_tdata[17:12] != t.outer)
                  report_mismatch("outer_count", rsp_tdata[17:12], t.outer);
               if (rsp_tdata[18] != t.ovf)
                  report_mismatch("overflow_flag", rsp_tdata[18], t.ovf);
               if (rsp_tdata[23:19] != '0)
                  report_mismatch("tdata padding", rsp_tdata[23:19], 0);
               if (rsp_tlast != t.last)
                  report_mismatch("last_result", rsp_tlast, t.last);
            end
         end
      end
   end

   // sender
   always @(negedge clock) begin
      logic     offer;
      span_type sp;
      if (!reset) begin
         offer = req_tvalid;
         if (req_taken) begin
            offer     = 1'b0;
            send_wait = send_calm ? 0 : $urandom_range(0, 14);
         end
         if (!offer) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (pending_spans.size() > 0) begin
               sp = pending_spans.pop_front();
               req_tdata <= {sp.hi, sp.lo};
               req_tlast <= sp.last;
               offer = 1'b1;
               if (sp.last) send_calm = ($urandom_range(0, 3) == 0);
            end
         end
         req_tvalid <= offer;
      end
   end

   // receiver
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) recv_wait = recv_calm ? 0 : $urandom_range(0, 14);
         if (rsp_tvalid && recv_wait > 0) recv_wait--;
         rsp_tready <= (recv_wait == 0) && (long_hold == 0);
      end
   end

   // one long receiver stall mid-emission so the input side backs up
   always @(negedge clock) begin
      if (!reset) begin
         if (long_hold > 0)
            long_hold <= long_hold - 1;
         else if (!hold_done && rsp_tvalid && results_seen >= 40) begin
            long_hold <= 600;
            hold_done = 1'b1;
         end
      end
   end

   task automatic queue_span(input bit [31:0] lo, input bit [31:0] hi, input bit last);
      span_type sp;
      sp.lo   = lo;
      sp.hi   = hi;
      sp.last = last;
      pending_spans.push_back(sp);
   endtask

   function automatic bit [31:0] pick_point(input int style);
      case (style)
         0: return $urandom;
         1: return $urandom_range(0, 15);
         2: return 32'hFFFF_FFFF - $urandom_range(0, 15);
         default: return $urandom_range(0, 1) ? $urandom : $urandom_range(0, 15);
      endcase
   endfunction

   task automatic queue_random_set(input int size);
      int        style;
      bit [31:0] a;
      bit [31:0] b;
      style = $urandom_range(0, 3);
      for (int k = 0; k < size; k++) begin
         a = pick_point(style);
         b = pick_point(style);
         // mostly well-formed, some inverted
         if ($urandom_range(0, 99) < 85 && a > b) queue_span(b, a, k == size - 1);
         else queue_span(a, b, k == size - 1);
      end
   endtask

   initial begin
      int queued;
      int size;
      bit full_done;
      bit over_done;

      // single range
      queue_span(32'd0, 32'd0, 1'b1);
      // extremes, duplicate, nesting, inverted
      queue_span(32'd0, 32'hFFFF_FFFF, 1'b0);
      queue_span(32'd10, 32'd20, 1'b0);
      queue_span(32'd10, 32'd20, 1'b0);
      queue_span(32'd12, 32'd15, 1'b0);
      queue_span(32'hFFFF_FFFF, 32'd0, 1'b0);
      queue_span(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      queue_span(32'd0, 32'd0, 1'b1);
      // inverted against normal
      queue_span(32'd30, 32'd10, 1'b0);
      queue_span(32'd10, 32'd30, 1'b0);
      queue_span(32'd20, 32'd20, 1'b1);
      // triple duplicate
      queue_span(32'd7, 32'd9, 1'b0);
      queue_span(32'd7, 32'd9, 1'b0);
      queue_span(32'd7, 32'd9, 1'b1);

      queued    = 14;
      full_done = 1'b0;
      over_done = 1'b0;
      while (queued < 360) begin
         if (!full_done && queued > 100) begin
            size      = HELD_MAX;
            full_done = 1'b1;
         end else if (!over_done && queued > 200) begin
            // overflow; the final range is dropped too
            size      = HELD_MAX + 2;
            over_done = 1'b1;
         end else if ($urandom_range(0, 9) < 8) begin
            size = $urandom_range(1, 8);
         end else begin
            size = $urandom_range(9, 20);
         end
         queue_random_set(size);
         queued += size;
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_spans.size() > 0 || req_tvalid) @(posedge clock);
      while (tally_q.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);

      if (error_count == 0 && tally_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== nested_range_count_core.f =====
rtl/nrc_pkg.sv
rtl/nrc_ctrl.sv
rtl/nrc_datapath.sv
rtl/nested_range_count_core.sv
tb/tb_top.sv
